### rtl/core/csgc_pkg.sv
// Shared types, codes and the character decode for the set signature group counter.
`timescale 1ns / 1ps

package csgc_pkg;

   localparam int SET_W   = 62;
   localparam int CHAR_W  = 8;
   localparam int QIDX_W  = 10;
   localparam int MATCH_W = 11;
   localparam int FUNC_W  = 2;

   localparam logic [FUNC_W-1:0] FUNC_CHAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_END   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

   localparam logic [CHAR_W-1:0] CH_DIGIT_LO = 8'h30; // '0'
   localparam logic [CHAR_W-1:0] CH_DIGIT_HI = 8'h39; // '9'
   localparam logic [CHAR_W-1:0] CH_LOWER_LO = 8'h61; // 'a'
   localparam logic [CHAR_W-1:0] CH_LOWER_HI = 8'h7a; // 'z'
   localparam logic [CHAR_W-1:0] CH_UPPER_LO = 8'h41; // 'A'
   localparam logic [CHAR_W-1:0] CH_UPPER_HI = 8'h5a; // 'Z'
   localparam logic [CHAR_W-1:0] LOWER_BASE  = 8'd10;
   localparam logic [CHAR_W-1:0] UPPER_BASE  = 8'd36;

   typedef struct packed {
      logic add_char;
      logic end_str;
      logic clear;
      logic key_read;
      logic key_latch;
      logic scan_step;
      logic emit;
      logic emit_err;
   } csgc_cmd_type;

   typedef struct packed {
      logic room;
      logic query_ok;
      logic scan_done;
      logic full;
   } csgc_stat_type;

   // One-hot set bit for a character byte; zero for anything not alphanumeric.
   function automatic logic [SET_W-1:0] char_mask(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] pos;
      logic              hit;
      pos = '0;
      hit = 1'b0;
      if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) begin
         pos = c - CH_DIGIT_LO;
         hit = 1'b1;
      end else if (c >= CH_LOWER_LO && c <= CH_LOWER_HI) begin
         pos = c - CH_LOWER_LO + LOWER_BASE;
         hit = 1'b1;
      end else if (c >= CH_UPPER_LO && c <= CH_UPPER_HI) begin
         pos = c - CH_UPPER_LO + UPPER_BASE;
         hit = 1'b1;
      end
      char_mask = hit ? (SET_W'(1) << pos[5:0]) : '0;
   endfunction

endpackage

### rtl/core/csgc_dp.sv
// Datapath: set builder, set store, string count and the match scan.
`timescale 1ns / 1ps

module csgc_dp #(
   parameter int MAX_STRINGS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  csgc_pkg::csgc_cmd_type       cmd,
   input  logic [csgc_pkg::CHAR_W-1:0]  char_code,
   input  logic [csgc_pkg::QIDX_W-1:0]  query_index,
   output csgc_pkg::csgc_stat_type      stat,
   output logic [csgc_pkg::MATCH_W-1:0] match_count
);
   import csgc_pkg::*;

   localparam int IDX_W = (MAX_STRINGS > 2) ? $clog2(MAX_STRINGS) : 1;
   localparam int CNT_W = $clog2(MAX_STRINGS + 1);
   localparam int QW    = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;
   localparam int MW    = (CNT_W > MATCH_W) ? CNT_W : MATCH_W;

   logic [SET_W-1:0] mem [MAX_STRINGS];

   logic [SET_W-1:0] set_ff, set_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             full_ff, full_in;
   logic [SET_W-1:0] key_ff;
   logic [SET_W-1:0] rd_data_ff;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] match_ff, match_in;
   logic [IDX_W-1:0] rd_addr;
   logic [QW-1:0]    qi_ext;
   logic [MW-1:0]    match_ext;
   logic             room;

   assign qi_ext  = QW'(query_index);
   assign room    = (cnt_ff < CNT_W'(MAX_STRINGS));
   assign rd_addr = cmd.key_read ? qi_ext[IDX_W-1:0] : scan_ff[IDX_W-1:0];

   assign stat.room      = room;
   assign stat.query_ok  = (qi_ext < QW'(cnt_ff));
   assign stat.scan_done = !pend_ff;
   assign stat.full      = full_ff;

   assign match_ext   = MW'(match_ff);
   assign match_count = match_ext[MATCH_W-1:0];

   always_comb begin
      set_in   = set_ff;
      cnt_in   = cnt_ff;
      full_in  = full_ff;
      scan_in  = scan_ff;
      pend_in  = pend_ff;
      match_in = match_ff;
      if (cmd.add_char) begin
         set_in = set_ff | char_mask(char_code);
      end
      if (cmd.end_str) begin
         set_in = '0;
         if (room) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            full_in = 1'b1;
         end
      end
      if (cmd.clear) begin
         set_in  = '0;
         cnt_in  = '0;
         full_in = 1'b0;
      end
      if (cmd.key_read) begin
         scan_in  = '0;
         pend_in  = 1'b0;
         match_in = '0;
      end
      // entry 0 is issued while the key arrives
      if (cmd.key_latch) begin
         scan_in = CNT_W'(1);
         pend_in = 1'b1;
      end
      if (cmd.scan_step) begin
         if (pend_ff && rd_data_ff == key_ff) begin
            match_in = match_ff + CNT_W'(1);
         end
         if (scan_ff < cnt_ff) begin
            scan_in = scan_ff + CNT_W'(1);
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff   <= '0;
         cnt_ff   <= '0;
         full_ff  <= 1'b0;
         scan_ff  <= '0;
         pend_ff  <= 1'b0;
         match_ff <= '0;
      end else begin
         set_ff   <= set_in;
         cnt_ff   <= cnt_in;
         full_ff  <= full_in;
         scan_ff  <= scan_in;
         pend_ff  <= pend_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.end_str && room) begin
         mem[cnt_ff[IDX_W-1:0]] <= set_ff;
      end
      rd_data_ff <= mem[rd_addr];
      if (cmd.key_latch) begin
         key_ff <= rd_data_ff;
      end
   end

endmodule

### rtl/core/csgc_ctrl.sv
// Controller: sequences word intake, the key read, the store scan and the result.
`timescale 1ns / 1ps

module csgc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [csgc_pkg::FUNC_W-1:0] func,
   input  csgc_pkg::csgc_stat_type     stat,
   input  logic                        out_free,
   output csgc_pkg::csgc_cmd_type      cmd
);
   import csgc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_KEY  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       err_ff, err_in;
   logic       take;

   assign in_ready = (state_ff == ST_IDLE);
   assign take     = in_valid && in_ready;

   always_comb begin
      state_in = state_ff;
      err_in   = err_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (func)
                  FUNC_CHAR: begin
                     cmd.add_char = 1'b1;
                  end
                  FUNC_END: begin
                     cmd.end_str = 1'b1;
                     if (!stat.room) begin
                        err_in   = 1'b1;
                        state_in = ST_EMIT;
                     end
                  end
                  FUNC_QUERY: begin
                     if (stat.query_ok) begin
                        cmd.key_read = 1'b1;
                        err_in       = 1'b0;
                        state_in     = ST_KEY;
                     end else begin
                        err_in   = 1'b1;
                        state_in = ST_EMIT;
                     end
                  end
                  FUNC_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                     cmd.clear = 1'b1;
                  end
               endcase
            end
         end
         ST_KEY: begin
            cmd.key_latch = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register can take the word
            if (out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_err = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
   end

endmodule

### rtl/core/char_set_signature_group_count_unit.sv
// Character and clear words, and end-of-string words with room, give no result; intake stays open.
// An error result passes the emit state into the output register; a query in range passes the key
// read, the key latch, a scan of the stored strings at one entry per cycle, and the emit state.
// Intake stalls from a query or error word until the emit state has loaded the output register.
// Synchronous active-high reset clears the current set, string count and full flag;
// the set store is not cleared and is read only below the string count.
`timescale 1ns / 1ps

module char_set_signature_group_count_unit #(
   parameter int MAX_STRINGS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] char_code, [17:8] query_index, [23:18] zero
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [10:0] match_count, [15:11] zero
   output logic [0:0]  rsp_tuser    // [0] index_error
);
   import csgc_pkg::*;

   csgc_cmd_type         cmd;
   csgc_stat_type        stat;
   logic [MATCH_W-1:0]   match_count;
   logic                 out_free;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MATCH_W-1:0]   rsp_count_ff;
   logic                 rsp_err_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   csgc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .func     (req_tuser),
      .stat     (stat),
      .out_free (out_free),
      .cmd      (cmd)
   );

   csgc_dp #(
      .MAX_STRINGS (MAX_STRINGS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .char_code   (req_tdata[7:0]),
      .query_index (req_tdata[17:8]),
      .stat        (stat),
      .match_count (match_count)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_count_ff <= cmd.emit_err ? '0 : match_count;
         rsp_err_ff   <= cmd.emit_err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_count_ff};
   assign rsp_tuser  = rsp_err_ff;

`ifndef SYNTH
   a_full_no_room: assert property (@(posedge clock) disable iff (reset)
      stat.full |-> !stat.room)
      else $error("full flag set while the store has room");

   a_err_zero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[10:0] == '0)
      else $error("error result carries a nonzero count");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == FUNC_QUERY |=> !req_tready)
      else $error("intake reopened right after a query word");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result loaded over an untaken result");
`endif

endmodule

### tb/char_set_signature_group_count_checker.sv
// Checker for the set signature group counter: tracks the stored sets and compares results.
`timescale 1ns / 1ps

module char_set_signature_group_count_checker #(
   parameter int MAX_STRINGS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] char_code, [17:8] query_index, [23:18] zero
   input  logic [1:0]  req_tuser,   // [1:0] func
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [10:0] match_count, [15:11] zero
   input  logic [0:0]  rsp_tuser,   // [0] index_error
   output int          mismatch_count,
   output int          awaited
);
   import csgc_pkg::*;

   typedef struct packed {
      logic [MATCH_W-1:0] match_count;
      logic               index_error;
   } group_answer_type;

   group_answer_type  answers_due[$];
   logic [SET_W-1:0]  building_set;
   logic [SET_W-1:0]  signatures[MAX_STRINGS];
   int unsigned       stored;
   int                mismatches;

   initial begin
      mismatches     = 0;
      building_set   = '0;
      stored         = 0;
   end

   // Bit position of an alphanumeric byte, -1 for anything else.
   function automatic int char_position(input logic [CHAR_W-1:0] c);
      if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) begin
         return int'(c) - int'(CH_DIGIT_LO);
      end
      if (c >= CH_LOWER_LO && c <= CH_LOWER_HI) begin
         return int'(c) - int'(CH_LOWER_LO) + int'(LOWER_BASE);
      end
      if (c >= CH_UPPER_LO && c <= CH_UPPER_HI) begin
         return int'(c) - int'(CH_UPPER_LO) + int'(UPPER_BASE);
      end
      return -1;
   endfunction

   function automatic logic [MATCH_W-1:0] same_set_count(input int unsigned idx);
      int unsigned n;
      n = 0;
      for (int unsigned i = 0; i < stored; i++) begin
         if (signatures[i] == signatures[idx]) begin
            n++;
         end
      end
      return MATCH_W'(n);
   endfunction

   always @(posedge clock) begin : track
      group_answer_type   got;
      group_answer_type   want;
      int                 pos;
      logic [FUNC_W-1:0]  func;
      logic [CHAR_W-1:0]  code;
      logic [QIDX_W-1:0]  qidx;
      if (reset) begin
         building_set = '0;
         stored       = 0;
         answers_due.delete();
         awaited <= 0;
      end else begin
         // Results first: a result never belongs to a word taken in the same cycle.
         if (rsp_tvalid && rsp_tready) begin
            got.match_count = rsp_tdata[MATCH_W-1:0];
            got.index_error = rsp_tuser[0];
            if (answers_due.size() == 0) begin
               $error("unexpected result word: match_count %0d index_error %0d",
                      got.match_count, got.index_error);
               mismatches++;
            end else begin
               want = answers_due.pop_front();
               if (got.match_count !== want.match_count) begin
                  $error("match_count: expected %0d, got %0d",
                         want.match_count, got.match_count);
                  mismatches++;
               end
               if (got.index_error !== want.index_error) begin
                  $error("index_error: expected %0d, got %0d",
                         want.index_error, got.index_error);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            func = req_tuser;
            code = req_tdata[CHAR_W-1:0];
            qidx = req_tdata[CHAR_W +: QIDX_W];
            case (func)
               FUNC_CHAR: begin
                  pos = char_position(code);
                  if (pos >= 0) begin
                     building_set[pos] = 1'b1;
                  end
               end
               FUNC_END: begin
                  if (stored < MAX_STRINGS) begin
                     signatures[stored] = building_set;
                     stored++;
                  end else begin
                     // Store full: drop the set and flag it.
                     want.match_count = '0;
                     want.index_error = 1'b1;
                     answers_due.push_back(want);
                  end
                  building_set = '0;
               end
               FUNC_QUERY: begin
                  if (qidx >= stored) begin
                     want.match_count = '0;
                     want.index_error = 1'b1;
                  end else begin
                     want.match_count = same_set_count(qidx);
                     want.index_error = 1'b0;
                  end
                  answers_due.push_back(want);
               end
               default: begin
                  stored       = 0;
                  building_set = '0;
               end
            endcase
         end
         awaited <= answers_due.size();
      end
      mismatch_count <= mismatches;
   end

endmodule

### tb/tb_char_set_signature_group_count_unit.sv
// Testbench top for the set signature group counter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_char_set_signature_group_count_unit;
   import csgc_pkg::*;

   localparam int STORE_DEPTH  = 1024;
   localparam int RANDOM_WORDS = 450;
   localparam int STALL_LIMIT  = 20000;
   localparam int SETTLE       = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [7:0] char_code, [17:8] query_index, [23:18] zero
   logic [1:0]  req_tuser  = '0;   // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [10:0] match_count, [15:11] zero
   logic [0:0]  rsp_tuser;         // [0] index_error

   int mismatch_count;
   int awaited;
   int idle_cycles = 0;
   int sent        = 0;
   int stored      = 0;
   int n_char      = 0;
   int n_end       = 0;
   int n_query     = 0;
   int n_clear     = 0;
   int n_overflow  = 0;
   int peak_stored = 0;
   bit calm        = 1'b0;
   bit rsp_calm    = 1'b0;

   char_set_signature_group_count_unit #(
      .MAX_STRINGS(STORE_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   char_set_signature_group_count_checker #(
      .MAX_STRINGS(STORE_DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .awaited        (awaited)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Count cycles with no word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random stalls between words, with calm stretches.
   initial begin : drain
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(31, 0) == 0) begin
            rsp_calm = !rsp_calm;
         end
         stall = rsp_calm ? 0 : $urandom_range(12, 0);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic push_word(input logic [FUNC_W-1:0] func, input logic [CHAR_W-1:0] code,
                            input logic [QIDX_W-1:0] qidx);
      int gap;
      if ($urandom_range(47, 0) == 0) begin
         calm = !calm;
      end
      gap = calm ? 0 : $urandom_range(12, 0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {6'b0, qidx, code};
      do @(posedge clock); while (!req_tready);
      sent++;
      case (func)
         FUNC_CHAR: n_char++;
         FUNC_END: begin
            n_end++;
            if (stored < STORE_DEPTH) begin
               stored++;
            end else begin
               n_overflow++;
            end
            if (stored > peak_stored) begin
               peak_stored = stored;
            end
         end
         FUNC_QUERY: n_query++;
         default: begin
            n_clear++;
            stored = 0;
         end
      endcase
   endtask

   // Hold off until every expected result word has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
   endtask

   // Often a small alphabet so that equal sets are common.
   function automatic logic [CHAR_W-1:0] pick_char();
      int r;
      r = $urandom_range(9, 0);
      if (r < 4) begin
         case ($urandom_range(3, 0))
            0: return CH_LOWER_LO;
            1: return CH_LOWER_LO + 8'd1;
            2: return CH_DIGIT_LO;
            default: return CH_UPPER_HI;
         endcase
      end
      if (r < 7) begin
         case ($urandom_range(2, 0))
            0: return CH_DIGIT_LO + CHAR_W'($urandom_range(9, 0));
            1: return CH_LOWER_LO + CHAR_W'($urandom_range(25, 0));
            default: return CH_UPPER_LO + CHAR_W'($urandom_range(25, 0));
         endcase
      end
      return CHAR_W'($urandom_range(255, 0));
   endfunction

   initial begin : stimulus
      int                 start;
      int                 pick;
      int                 len;
      logic [QIDX_W-1:0]  qidx;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Range edges and the bytes just outside each range.
      push_word(FUNC_CHAR, CH_DIGIT_LO, '0);
      push_word(FUNC_CHAR, CH_DIGIT_HI, '1);
      push_word(FUNC_CHAR, CH_LOWER_LO, '0);
      push_word(FUNC_CHAR, CH_LOWER_HI, '1);
      push_word(FUNC_CHAR, CH_UPPER_LO, '0);
      push_word(FUNC_CHAR, CH_UPPER_HI, '1);
      push_word(FUNC_CHAR, 8'h00, '0);
      push_word(FUNC_CHAR, 8'hff, '1);
      push_word(FUNC_CHAR, CH_DIGIT_LO - 8'd1, '0);
      push_word(FUNC_CHAR, CH_DIGIT_HI + 8'd1, '0);
      push_word(FUNC_CHAR, CH_UPPER_LO - 8'd1, '0);
      push_word(FUNC_CHAR, CH_UPPER_HI + 8'd1, '0);
      push_word(FUNC_CHAR, CH_LOWER_LO - 8'd1, '0);
      push_word(FUNC_CHAR, CH_LOWER_HI + 8'd1, '0);
      push_word(FUNC_END, 8'hff, '1);
      push_word(FUNC_QUERY, 8'hff, '0);
      push_word(FUNC_QUERY, '0, '1);
      push_word(FUNC_END, '0, '0);       // empty string
      push_word(FUNC_QUERY, '0, 10'd1);
      push_word(FUNC_CLEAR, 8'hff, '1);
      push_word(FUNC_QUERY, '0, '0);     // nothing stored after clear
      push_word(FUNC_END, '0, '0);
      push_word(FUNC_QUERY, '0, '0);
      wait_drained();

      // Fill the store with empty sets, overflow it, then ask for the full count.
      push_word(FUNC_CLEAR, '0, '0);
      repeat (STORE_DEPTH + 2) push_word(FUNC_END, pick_char(), QIDX_W'($urandom_range(1023, 0)));
      push_word(FUNC_QUERY, '0, '0);
      push_word(FUNC_QUERY, '0, '1);
      push_word(FUNC_CLEAR, '0, '0);
      wait_drained();

      start = sent;
      while (sent < start + RANDOM_WORDS) begin
         pick = $urandom_range(99, 0);
         if (stored > 48) begin
            push_word(FUNC_CLEAR, CHAR_W'($urandom), QIDX_W'($urandom));
         end else if (pick < 55) begin
            len = $urandom_range(8, 0);
            repeat (len) push_word(FUNC_CHAR, pick_char(), QIDX_W'($urandom));
            push_word(FUNC_END, CHAR_W'($urandom), QIDX_W'($urandom));
         end else if (pick < 88) begin
            if (stored > 0 && $urandom_range(4, 0) != 0) begin
               qidx = QIDX_W'($urandom_range(stored - 1, 0));
            end else begin
               qidx = QIDX_W'($urandom);
            end
            push_word(FUNC_QUERY, CHAR_W'($urandom), qidx);
         end else if (pick < 92) begin
            push_word(FUNC_CLEAR, CHAR_W'($urandom), QIDX_W'($urandom));
         end else begin
            push_word(FUNC_W'($urandom), CHAR_W'($urandom), QIDX_W'($urandom));
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d words: %0d characters, %0d string ends, %0d queries, %0d clears.",
               sent, n_char, n_end, n_query, n_clear);
      $display("Store reached %0d strings; %0d string ends met a full store.",
               peak_stored, n_overflow);
      if (mismatch_count == 0 && awaited == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
